>>> src/poc_pkg.sv
// Shared types, register map, reset values and helpers for the phase
// overcurrent trip block. No dependencies.
package poc_pkg;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_RUN   = 2'd1,
    MODE_CALIB = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    FAULT_NONE  = 2'd0,
    FAULT_CALIB = 2'd1,
    FAULT_RUN   = 2'd2
  } fault_t;

  typedef enum logic [1:0] {
    REG_RUN_LIMIT   = 2'd0,
    REG_CALIB_LIMIT = 2'd1,
    REG_CALIB_HARD  = 2'd2,
    REG_TRIP_COUNT  = 2'd3
  } reg_idx_t;

  localparam int AddrWidth = 4;
  localparam int DataWidth = 32;

  localparam logic [14:0] RunLimitReset   = 15'd16384;
  localparam logic [14:0] CalibLimitReset = 15'd8192;
  localparam logic [14:0] CalibHardReset  = 15'd12288;
  localparam logic [15:0] TripCountReset  = 16'd4;
  localparam logic [15:0] CountMax        = 16'hFFFF;

  typedef struct packed {
    logic [14:0] run_limit;
    logic [14:0] calib_limit;
    logic [14:0] calib_hard;
    logic [15:0] trip_count;
  } cfg_t;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [15:0] current_u;
    logic signed [15:0] current_v;
    logic signed [15:0] current_w;
  } sample_t;

  typedef struct packed {
    logic               tripped;
    logic               hard_exceeded;
    logic               abort_calibration;
    logic               shutdown_pwm;
    logic [1:0]         first_fault;
    logic [14:0]        peak_current;
    logic [14:0]        max_peak_seen;
    logic [15:0]        over_limit_run;
    logic signed [15:0] trip_u;
    logic signed [15:0] trip_v;
    logic signed [15:0] trip_w;
  } result_t;

  // Magnitude of a two's complement sample; the most negative code maps to 32767.
  function automatic logic [14:0] abs_sat(input logic signed [15:0] x);
    logic [15:0] neg;
    neg = 16'(~x) + 16'd1;
    if (!x[15]) begin
      return x[14:0];
    end else if (neg[15]) begin
      return 15'h7FFF;
    end else begin
      return neg[14:0];
    end
  endfunction

endpackage

>>> src/phase_overcurrent_trip.sv
// Top level of the phase overcurrent trip block: sample register, trip
// evaluation, protection state and result register. Depends on poc_pkg, poc_regs.
//
// Usage: each request on the sample channel carries the controller mode and
// one sample of the three phase currents. Every request produces exactly one
// result request with the peak magnitude, the trip flags, the latched fault
// code, the consecutive over-limit count and the currents captured at the
// most recent trip.
// A sample is captured in the sample register, evaluated against the limits
// and protection state, and its result is then captured in the result
// register. Throughput is one sample per cycle while the result is not
// stalled; the only loop is the update of the over-limit count, peak
// maximum, fault latch and captures.
// A stalled result holds the result register; the sample register then
// holds too and sample_stall rises once it is full, so nothing is dropped.
// Reset clears the limits to their defaults, the count, peak maximum, fault
// latch and captures to zero, and empties both registers. Limits are written
// through APB while no sample is in flight; the user ensures it, not the block.
module phase_overcurrent_trip
  import poc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 sample_valid,
  output logic                 sample_stall,
  input  sample_t              sample,
  output logic                 result_valid,
  input  logic                 result_stall,
  output result_t              result,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [DataWidth-1:0] pwdata,
  output logic [DataWidth-1:0] prdata,
  output logic                 pready
);

  cfg_t    cfg;
  logic    smp_valid;
  sample_t smp;
  logic    out_free;
  logic    advance;

  logic [15:0]        over_count;
  logic [14:0]        max_peak;
  fault_t             latched_fault;
  logic signed [15:0] capture_u;
  logic signed [15:0] capture_v;
  logic signed [15:0] capture_w;

  logic [15:0]        over_count_next;
  logic [14:0]        max_peak_next;
  fault_t             latched_fault_next;
  logic signed [15:0] capture_u_next;
  logic signed [15:0] capture_v_next;
  logic signed [15:0] capture_w_next;
  result_t            result_next;

  logic        active;
  logic        calib;
  logic [14:0] mag_u;
  logic [14:0] mag_v;
  logic [14:0] mag_w;
  logic [14:0] peak_uv;
  logic [14:0] peak;
  logic [14:0] soft_lim;
  logic [14:0] hard_lim;
  logic        hard;
  logic        trip;

  poc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign out_free     = !result_valid || !result_stall;
  assign advance      = smp_valid && out_free;
  assign sample_stall = smp_valid && !out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      smp_valid <= 1'b0;
    end else if (!sample_stall) begin
      smp_valid <= sample_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!sample_stall) begin
      smp <= sample;
    end
  end

  // Trip evaluation. Modes other than run and calibrate act as idle.
  always_comb begin
    active   = (smp.mode == MODE_RUN) || (smp.mode == MODE_CALIB);
    calib    = (smp.mode == MODE_CALIB);
    mag_u    = abs_sat(smp.current_u);
    mag_v    = abs_sat(smp.current_v);
    mag_w    = abs_sat(smp.current_w);
    peak_uv  = (mag_v > mag_u) ? mag_v : mag_u;
    peak     = (mag_w > peak_uv) ? mag_w : peak_uv;
    soft_lim = calib ? cfg.calib_limit : cfg.run_limit;
    hard_lim = calib ? cfg.calib_hard : cfg.run_limit;
    hard     = active && (peak > hard_lim);

    if (!active || peak <= soft_lim) begin
      over_count_next = '0;
    end else if (over_count == CountMax) begin
      over_count_next = over_count;
    end else begin
      over_count_next = over_count + 16'd1;
    end

    trip          = active && (hard || over_count_next >= cfg.trip_count);
    max_peak_next = (active && peak > max_peak) ? peak : max_peak;

    latched_fault_next = latched_fault;
    if (trip && latched_fault == FAULT_NONE) begin
      latched_fault_next = calib ? FAULT_CALIB : FAULT_RUN;
    end

    capture_u_next = trip ? smp.current_u : capture_u;
    capture_v_next = trip ? smp.current_v : capture_v;
    capture_w_next = trip ? smp.current_w : capture_w;

    result_next.tripped           = trip;
    result_next.hard_exceeded     = hard;
    result_next.abort_calibration = trip && calib;
    result_next.shutdown_pwm      = trip && !calib;
    result_next.first_fault       = latched_fault_next;
    result_next.peak_current      = active ? peak : '0;
    result_next.max_peak_seen     = max_peak_next;
    result_next.over_limit_run    = over_count_next;
    result_next.trip_u            = capture_u_next;
    result_next.trip_v            = capture_v_next;
    result_next.trip_w            = capture_w_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      over_count    <= '0;
      max_peak      <= '0;
      latched_fault <= FAULT_NONE;
      capture_u     <= '0;
      capture_v     <= '0;
      capture_w     <= '0;
    end else if (advance) begin
      over_count    <= over_count_next;
      max_peak      <= max_peak_next;
      latched_fault <= latched_fault_next;
      capture_u     <= capture_u_next;
      capture_v     <= capture_v_next;
      capture_w     <= capture_w_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_free) begin
      result_valid <= smp_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= result_next;
    end
  end

  // A trip flags exactly one of calibration abort and PWM shutdown.
  a_trip_action: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.tripped |-> result.abort_calibration != result.shutdown_pwm)
    else $error("trip without exactly one action flag");

  // Action flags only accompany a trip, and a hard exceedance always trips.
  a_flags_need_trip: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.tripped |->
      !result.abort_calibration && !result.shutdown_pwm && !result.hard_exceeded)
    else $error("action or hard flag without trip");

  // The peak of a sample never exceeds the running maximum reported with it.
  a_peak_bound: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.peak_current <= result.max_peak_seen)
    else $error("peak above reported maximum");

  // The running maximum never falls between resets.
  a_max_monotonic: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> max_peak >= $past(max_peak))
    else $error("peak maximum decreased");

  // Once a fault is latched it keeps its code until reset.
  a_fault_sticky: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $past(latched_fault) != FAULT_NONE |->
      latched_fault == $past(latched_fault))
    else $error("latched fault changed");

endmodule

>>> src/poc_regs.sv
// APB-style configuration registers for the phase overcurrent trip block.
// Depends on poc_pkg for the register map and reset values.
module poc_regs
  import poc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [DataWidth-1:0] pwdata,
  output logic [DataWidth-1:0] prdata,
  output logic                 pready,
  output cfg_t                 cfg
);

  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.run_limit   <= RunLimitReset;
      cfg.calib_limit <= CalibLimitReset;
      cfg.calib_hard  <= CalibHardReset;
      cfg.trip_count  <= TripCountReset;
    end else if (wr_en) begin
      unique case (idx)
        REG_RUN_LIMIT:   cfg.run_limit   <= pwdata[14:0];
        REG_CALIB_LIMIT: cfg.calib_limit <= pwdata[14:0];
        REG_CALIB_HARD:  cfg.calib_hard  <= pwdata[14:0];
        REG_TRIP_COUNT:  cfg.trip_count  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_RUN_LIMIT:   prdata = {17'd0, cfg.run_limit};
      REG_CALIB_LIMIT: prdata = {17'd0, cfg.calib_limit};
      REG_CALIB_HARD:  prdata = {17'd0, cfg.calib_hard};
      REG_TRIP_COUNT:  prdata = {16'd0, cfg.trip_count};
      default:         prdata = '0;
    endcase
  end

endmodule
